// ----- src/set_assoc_lru_lookup_core_assert.svh -----
// Assertion macros shared by the lookup core.
`ifndef SET_ASSOC_LRU_LOOKUP_CORE_ASSERT_SVH
`define SET_ASSOC_LRU_LOOKUP_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SALRU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SALRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/salru_pkg.sv -----
package salru_pkg;

    typedef struct packed {
        logic [5:0]  set_index;
        logic [23:0] tag;
    } t_in_beat;

    typedef enum logic [1:0] {
        KIND_HIT      = 2'd0,
        KIND_COLD     = 2'd1,
        KIND_CONFLICT = 2'd2
    } t_access_kind;

    typedef struct packed {
        logic [2:0]   way;
        t_access_kind access_kind;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_META,
        ST_SCAN,
        ST_DONE
    } t_seq_state;

    // Control from the sequencer to the shared scan unit.
    typedef struct packed {
        logic start;       // clear the scan flags
        logic step;        // evaluate one recency position
        logic way_active;  // the way at this position takes part
        logic way_valid;   // the line at this position is valid
    } t_scan_ctl;

    localparam int CFG_BITS = 4;

endpackage

// ----- src/set_assoc_lru_lookup_core.sv -----
// Channel   Direction  Signals                         Payload
// in        input      i_in_valid / o_in_ready         i_in  (set_index, tag)
// out       output     o_out_valid / i_out_ready       o_out (way, access_kind)
// cfg       input      i_cfg_valid / o_cfg_ready       i_cfg_data (ways_in_use)
//
// Each lookup passes through the states IDLE (the beat is accepted and the
// set's metadata row is read), META (the first tag read is issued), SCAN, in
// which a single tag comparator walks the recency order one way per cycle, and
// DONE (commit); only then is the next beat taken. The one read port of the
// tag memory sets this walk. After reset, a clearing pass writes every metadata
// row; no input beat is taken during it. A stalled output holds the finished
// result, and the next lookup may run until its own commit while it waits.
module set_assoc_lru_lookup_core
    import salru_pkg::*;
#(
    parameter int SETS     = 64,
    parameter int WAYS     = 8,
    parameter int TAG_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_beat            i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_beat           o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int NW    = $clog2(WAYS + 1);
    localparam int LINES = SETS * WAYS;
    localparam int AW    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int OW    = WAYS * WW;
    localparam int MW    = WAYS * (WW + 1);
    localparam int SET_CODES = 64;
    localparam int RESET_WAYS = (8 > WAYS) ? WAYS : 8;

    t_seq_state          r_state, n_state;
    logic [SW-1:0]       r_set;
    logic [TAG_BITS-1:0] r_tag;
    logic [WW-1:0]       r_pos, n_pos;
    logic [SW-1:0]       r_clr_cnt;
    logic [NW-1:0]       r_ways_eff, n_ways_eff;
    t_out_beat           r_out;
    logic                r_out_valid;

    logic [SW-1:0]       w_set_lut [SET_CODES];
    logic [OW-1:0]       w_ident;
    logic [MW-1:0]       w_meta_rd;
    logic [OW-1:0]       w_order_vec;
    logic [WAYS-1:0]     w_valid_vec;
    logic                w_meta_we;
    logic [SW-1:0]       w_meta_waddr;
    logic [MW-1:0]       w_meta_wdata;
    logic                w_tag_we;
    logic                w_tag_re;
    logic [AW-1:0]       w_tag_waddr;
    logic [AW-1:0]       w_tag_raddr;
    logic [TAG_BITS-1:0] w_tag_rd;
    logic [WW-1:0]       w_iss_pos;
    logic [WW-1:0]       w_iss_way;
    logic [WW-1:0]       w_cmp_way;
    t_scan_ctl           w_scan_ctl;
    t_access_kind        w_kind;
    logic [WW-1:0]       w_sel_pos;
    logic [WW-1:0]       w_sel_way;
    logic [OW-1:0]       w_new_order;
    logic [WAYS-1:0]     w_new_valid;
    logic                w_accept;
    logic                w_commit;
    logic                w_last_pos;

    // Set index folded onto the sets that exist: a constant table over all
    // index codes, so no divider is needed.
    for (genvar g = 0; g < SET_CODES; g++) begin : g_set_lut
        assign w_set_lut[g] = SW'(g % SETS);
    end

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            w_ident[i*WW +: WW] = WW'(i);
        end
    end

    // A metadata row holds the set's valid bits above its recency order,
    // with the most recent way in the lowest slot.
    assign w_order_vec = w_meta_rd[OW-1:0];
    assign w_valid_vec = w_meta_rd[MW-1:OW];

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_commit   = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign w_last_pos = (r_pos == WW'(WAYS - 1));

    // Tag reads run one position ahead of the comparator: the read issued in
    // this cycle is compared in the next one.
    assign w_iss_pos = (r_state == ST_META) ? '0 : r_pos + 1'b1;
    assign w_iss_way = w_order_vec[w_iss_pos*WW +: WW];
    assign w_cmp_way = w_order_vec[r_pos*WW +: WW];

    assign w_tag_raddr = AW'(r_set) * AW'(WAYS) + AW'(w_iss_way);

    // The way that was hit or gets filled, and the set's new recency order
    // with that way moved to the front.
    assign w_sel_way   = w_order_vec[w_sel_pos*WW +: WW];
    assign w_tag_waddr = AW'(r_set) * AW'(WAYS) + AW'(w_sel_way);

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            if (i == 0) begin
                w_new_order[i*WW +: WW] = w_sel_way;
            end else if (i <= int'(w_sel_pos)) begin
                w_new_order[i*WW +: WW] = w_order_vec[(i-1)*WW +: WW];
            end else begin
                w_new_order[i*WW +: WW] = w_order_vec[i*WW +: WW];
            end
            w_new_valid[i] = w_valid_vec[i] || (w_sel_way == WW'(i));
        end
    end

    // Sequencer: next state and the strobes for the memories and scan unit.
    always_comb begin
        n_state           = r_state;
        n_pos             = r_pos;
        o_in_ready        = 1'b0;
        w_meta_we         = 1'b0;
        w_meta_waddr      = r_set;
        w_meta_wdata      = {w_new_valid, w_new_order};
        w_tag_we          = 1'b0;
        w_tag_re          = 1'b0;
        w_scan_ctl.start      = 1'b0;
        w_scan_ctl.step       = 1'b0;
        w_scan_ctl.way_active = int'(w_cmp_way) < int'(r_ways_eff);
        w_scan_ctl.way_valid  = w_valid_vec[w_cmp_way];
        case (r_state)
            ST_CLEAR: begin
                w_meta_we    = 1'b1;
                w_meta_waddr = r_clr_cnt;
                w_meta_wdata = {{WAYS{1'b0}}, w_ident};
                if (r_clr_cnt == SW'(SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept) begin
                    n_state = ST_META;
                end
            end
            ST_META: begin
                w_tag_re         = 1'b1;
                w_scan_ctl.start = 1'b1;
                n_pos            = '0;
                n_state          = ST_SCAN;
            end
            ST_SCAN: begin
                w_scan_ctl.step = 1'b1;
                if (w_last_pos) begin
                    n_state = ST_DONE;
                end else begin
                    w_tag_re = 1'b1;
                    n_pos    = r_pos + 1'b1;
                end
            end
            ST_DONE: begin
                if (w_commit) begin
                    w_meta_we = 1'b1;
                    w_tag_we  = (w_kind != KIND_HIT);
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // The associativity register stores its clamped value, so zero acts as
    // one and anything above WAYS acts as WAYS.
    always_comb begin
        if (i_cfg_data == '0) begin
            n_ways_eff = NW'(1);
        end else if (int'(i_cfg_data) > WAYS) begin
            n_ways_eff = NW'(WAYS);
        end else begin
            n_ways_eff = NW'(i_cfg_data);
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_ways_eff  <= NW'(RESET_WAYS);
        end else begin
            r_pos <= n_pos;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_ways_eff <= n_ways_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_set <= w_set_lut[i_in.set_index];
            r_tag <= TAG_BITS'(i_in.tag);
        end
        if (w_commit) begin
            r_out.way         <= 3'(w_sel_way);
            r_out.access_kind <= w_kind;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Metadata row per set: valid bits and recency order. Read once per
    // lookup at accept; the data stays on the port until the next accept.
    salru_ram #(
        .DEPTH (SETS),
        .WIDTH (MW)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (w_meta_we),
        .i_waddr (w_meta_waddr),
        .i_wdata (w_meta_wdata),
        .i_re    (w_accept),
        .i_raddr (w_set_lut[i_in.set_index]),
        .o_rdata (w_meta_rd)
    );

    // Tag per line, addressed by set and way.
    salru_ram #(
        .DEPTH (LINES),
        .WIDTH (TAG_BITS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_tag_we),
        .i_waddr (w_tag_waddr),
        .i_wdata (r_tag),
        .i_re    (w_tag_re),
        .i_raddr (w_tag_raddr),
        .o_rdata (w_tag_rd)
    );

    salru_scan #(
        .WAYS     (WAYS),
        .TAG_BITS (TAG_BITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_scan_ctl),
        .i_pos      (r_pos),
        .i_key_tag  (r_tag),
        .i_line_tag (w_tag_rd),
        .o_kind     (w_kind),
        .o_pos      (w_sel_pos)
    );

`include "set_assoc_lru_lookup_core_assert.svh"

    `SALRU_ASSERT_NEXT(a_accept_reads_meta, w_accept, r_state == ST_META, "accepted beat did not start a lookup")
    `SALRU_ASSERT_SAME(a_result_from_commit, $rose(r_out_valid), $past(r_state) == ST_DONE, "result appeared without a commit")
    `SALRU_ASSERT_SAME(a_scan_in_range, r_state == ST_SCAN, int'(r_pos) < WAYS, "scan position ran past the last way")

endmodule

// ----- src/salru_ram.sv -----
module salru_ram
    import salru_pkg::*;
#(
    parameter int DEPTH     = 512,
    parameter int WIDTH     = 24,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/salru_scan.sv -----
module salru_scan
    import salru_pkg::*;
#(
    parameter int WAYS      = 8,
    parameter int TAG_BITS  = 24,
    parameter int POS_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_scan_ctl           i_ctl,
    input  logic [POS_BITS-1:0] i_pos,
    input  logic [TAG_BITS-1:0] i_key_tag,
    input  logic [TAG_BITS-1:0] i_line_tag,
    output t_access_kind        o_kind,
    output logic [POS_BITS-1:0] o_pos
);

    logic                r_hit,       n_hit;
    logic                r_have_inv,  n_have_inv;
    logic                r_have_part, n_have_part;
    logic [POS_BITS-1:0] r_hit_pos,   n_hit_pos;
    logic [POS_BITS-1:0] r_inv_pos,   n_inv_pos;
    logic [POS_BITS-1:0] r_last_pos,  n_last_pos;
    logic                w_tag_eq;

    assign w_tag_eq = (i_line_tag == i_key_tag);

    // One recency position per step: the first matching valid way wins,
    // the first invalid way is kept as the fill candidate, and the last
    // active way seen is the least recently used one.
    always_comb begin
        n_hit       = r_hit;
        n_have_inv  = r_have_inv;
        n_have_part = r_have_part;
        n_hit_pos   = r_hit_pos;
        n_inv_pos   = r_inv_pos;
        n_last_pos  = r_last_pos;
        if (i_ctl.start) begin
            n_hit       = 1'b0;
            n_have_inv  = 1'b0;
            n_have_part = 1'b0;
            n_hit_pos   = '0;
            n_inv_pos   = '0;
            n_last_pos  = '0;
        end else if (i_ctl.step && i_ctl.way_active) begin
            n_have_part = 1'b1;
            n_last_pos  = i_pos;
            if (i_ctl.way_valid) begin
                if (!r_hit && w_tag_eq) begin
                    n_hit     = 1'b1;
                    n_hit_pos = i_pos;
                end
            end else if (!r_have_inv) begin
                n_have_inv = 1'b1;
                n_inv_pos  = i_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit       <= 1'b0;
            r_have_inv  <= 1'b0;
            r_have_part <= 1'b0;
        end else begin
            r_hit       <= n_hit;
            r_have_inv  <= n_have_inv;
            r_have_part <= n_have_part;
        end
        r_hit_pos  <= n_hit_pos;
        r_inv_pos  <= n_inv_pos;
        r_last_pos <= n_last_pos;
    end

    always_comb begin
        if (r_hit) begin
            o_kind = KIND_HIT;
            o_pos  = r_hit_pos;
        end else if (r_have_inv) begin
            o_kind = KIND_COLD;
            o_pos  = r_inv_pos;
        end else begin
            o_kind = KIND_CONFLICT;
            o_pos  = r_have_part ? r_last_pos : '0;
        end
    end

endmodule
